@@ hdl/pbse_pkg.sv @@
`default_nettype none

package pbse_pkg;

    // Width of the run counters. It holds a value width of up to 32 and a slot count of up to 31.
    localparam int CNT_W = 6;

    // Width of the gap and start count fields in frame_format.
    localparam int SLOT_W = 5;

    // Width of the symbol registers and of the symbol port.
    localparam int WORD_W = 32;

    // Register map. The byte address of each register is four times its index.
    typedef enum logic [2:0] {
        REG_VALUE_WIDTH      = 3'd0,
        REG_FRAME_FORMAT     = 3'd1,
        REG_SYMBOL_ONE       = 3'd2,
        REG_SYMBOL_ZERO      = 3'd3,
        REG_SYMBOL_GAP       = 3'd4,
        REG_SYMBOL_START     = 3'd5,
        REG_SYMBOL_SEPARATOR = 3'd6,
        REG_SYMBOL_END       = 3'd7
    } t_reg_idx;

    // Codes carried on the symbol_kind port.
    typedef logic [2:0] t_kind;
    localparam t_kind KIND_ZERO  = 3'd0;
    localparam t_kind KIND_ONE   = 3'd1;
    localparam t_kind KIND_GAP   = 3'd2;
    localparam t_kind KIND_START = 3'd3;
    localparam t_kind KIND_SEP   = 3'd4;
    localparam t_kind KIND_END   = 3'd5;

    // Bit positions inside frame_format.
    localparam int FF_MSB_FIRST = 0;
    localparam int FF_SEP_ON    = 1;
    localparam int FF_END_ON    = 2;
    localparam int FF_GAP_LO    = 3;
    localparam int FF_START_LO  = 8;

endpackage

`default_nettype wire

@@ hdl/pixel_bit_symbol_encoder_core.sv @@
`default_nettype none

// Pixel bit to pulse symbol encoder. Each input beat is turned into a run of
// 32-bit pulse symbol words for a one-wire LED or serial transmitter, one symbol
// per output beat.
// A frame-start beat (action 0) sends the gap symbol gap-count times, then the
// start symbol start-count times. Both counts come from frame_format.
// A value beat (action 1) sends one data symbol for each of the low value_width
// bits of intensity. The bit order is MSB or LSB first, as frame_format selects.
// After the data symbols it sends one end symbol if last_value is set and end
// marking is on. Otherwise it sends a separator symbol if separators are on.
// o_last_of_run marks the final symbol of each run.
// A value_width above MAX_VALUE_BITS is treated as MAX_VALUE_BITS.
// Only the low SYMBOL_BITS bits of a symbol register reach o_symbol.
// The block holds one input beat at a time. It raises o_in_stall until the
// final symbol of the run has been loaded into the output register.
// Symbols come from one shift register and one down counter under a small
// sequencer, one symbol per cycle while the output register is free.
// A beat that makes no symbols leaves the sequencer idle, so o_in_stall stays low.
// The output register lets the next beat be accepted while the last symbol
// still waits on i_out_stall.
// Configuration is written through the APB-style port at byte address 4 * index.
// Write configuration only while the block is idle.
module pixel_bit_symbol_encoder_core #(
    parameter int MAX_VALUE_BITS = 32,
    parameter int SYMBOL_BITS    = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // Input channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_action,
    input  wire logic [31:0] i_intensity,
    input  wire logic        i_last_value,

    // Output channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [31:0] o_symbol,
    output pbse_pkg::t_kind  o_symbol_kind,
    output logic             o_last_of_run
);

    import pbse_pkg::*;

    // Bits of a symbol register that reach the output port.
    localparam int SYM_KEEP = (SYMBOL_BITS < WORD_W) ? SYMBOL_BITS : WORD_W;
    localparam logic [WORD_W-1:0] SYM_MASK = {WORD_W{1'b1}} >> (WORD_W - SYM_KEEP);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GAP,
        ST_START,
        ST_DATA,
        ST_TAIL
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]  r_value_width;
    logic [12:0]       r_frame_format;
    logic [WORD_W-1:0] r_symbol_one;
    logic [WORD_W-1:0] r_symbol_zero;
    logic [WORD_W-1:0] r_symbol_gap;
    logic [WORD_W-1:0] r_symbol_start;
    logic [WORD_W-1:0] r_symbol_separator;
    logic [WORD_W-1:0] r_symbol_end;

    logic     w_cfg_write;
    t_reg_idx w_reg_idx;

    assign pready      = 1'b1;
    assign w_reg_idx   = t_reg_idx'(paddr[4:2]);
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_width      <= CNT_W'(8);
            r_frame_format     <= 13'd1;
            r_symbol_one       <= '0;
            r_symbol_zero      <= '0;
            r_symbol_gap       <= '0;
            r_symbol_start     <= '0;
            r_symbol_separator <= '0;
            r_symbol_end       <= '0;
        end else if (w_cfg_write) begin
            case (w_reg_idx)
                REG_VALUE_WIDTH:      r_value_width      <= pwdata[CNT_W-1:0];
                REG_FRAME_FORMAT:     r_frame_format     <= pwdata[12:0];
                REG_SYMBOL_ONE:       r_symbol_one       <= pwdata;
                REG_SYMBOL_ZERO:      r_symbol_zero      <= pwdata;
                REG_SYMBOL_GAP:       r_symbol_gap       <= pwdata;
                REG_SYMBOL_START:     r_symbol_start     <= pwdata;
                REG_SYMBOL_SEPARATOR: r_symbol_separator <= pwdata;
                REG_SYMBOL_END:       r_symbol_end       <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_VALUE_WIDTH:      prdata = {{(32-CNT_W){1'b0}}, r_value_width};
            REG_FRAME_FORMAT:     prdata = {19'd0, r_frame_format};
            REG_SYMBOL_ONE:       prdata = r_symbol_one;
            REG_SYMBOL_ZERO:      prdata = r_symbol_zero;
            REG_SYMBOL_GAP:       prdata = r_symbol_gap;
            REG_SYMBOL_START:     prdata = r_symbol_start;
            REG_SYMBOL_SEPARATOR: prdata = r_symbol_separator;
            REG_SYMBOL_END:       prdata = r_symbol_end;
            default:              prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Decode of the frame format and the effective value width.
    // ------------------------------------------------------------------
    logic              w_msb_first;
    logic              w_sep_on;
    logic              w_end_on;
    logic [SLOT_W-1:0] w_gaps;
    logic [SLOT_W-1:0] w_starts;
    logic [CNT_W-1:0]  w_width;
    logic [CNT_W-1:0]  w_align;

    assign w_msb_first = r_frame_format[FF_MSB_FIRST];
    assign w_sep_on    = r_frame_format[FF_SEP_ON];
    assign w_end_on    = r_frame_format[FF_END_ON];
    assign w_gaps      = r_frame_format[FF_GAP_LO +: SLOT_W];
    assign w_starts    = r_frame_format[FF_START_LO +: SLOT_W];

    // The width saturates at the size of the shift register.
    assign w_width = (r_value_width > CNT_W'(MAX_VALUE_BITS)) ?
                     CNT_W'(MAX_VALUE_BITS) : r_value_width;

    // For MSB-first order, the value is left-aligned so that its top bit sits at the shift
    // register's MSB.
    assign w_align = CNT_W'(MAX_VALUE_BITS) - w_width;

    // ------------------------------------------------------------------
    // Sequencer: one shift register, one down counter, one symbol per cycle while the output is free.
    // ------------------------------------------------------------------
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [SLOT_W-1:0]         r_starts, n_starts;
    logic [MAX_VALUE_BITS-1:0] r_shift, n_shift;
    logic                      r_msb, n_msb;
    logic                      r_tail, n_tail;
    logic                      r_tail_end, n_tail_end;
    logic                      r_out_valid, n_out_valid;
    logic [WORD_W-1:0]         r_symbol, n_symbol;
    t_kind                     r_kind, n_kind;
    logic                      r_last, n_last;

    logic w_in_accept;
    logic w_out_free;
    logic w_load;
    logic w_bit;
    logic w_sym_last;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_load      = (r_state != ST_IDLE) && w_out_free;
    assign w_bit       = r_msb ? r_shift[MAX_VALUE_BITS-1] : r_shift[0];

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_starts    = r_starts;
        n_shift     = r_shift;
        n_msb       = r_msb;
        n_tail      = r_tail;
        n_tail_end  = r_tail_end;
        n_out_valid = r_out_valid && i_out_stall;
        n_symbol    = r_symbol;
        n_kind      = r_kind;
        n_last      = r_last;
        w_sym_last  = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    if (!i_action) begin
                        // Frame start: gap slots first, then start slots.
                        n_starts = w_starts;
                        if (w_gaps != '0) begin
                            n_state = ST_GAP;
                            n_cnt   = CNT_W'(w_gaps);
                        end else if (w_starts != '0) begin
                            n_state = ST_START;
                            n_cnt   = CNT_W'(w_starts);
                        end
                    end else begin
                        n_msb      = w_msb_first;
                        n_tail_end = w_end_on && i_last_value;
                        n_tail     = (w_end_on && i_last_value) || w_sep_on;
                        n_cnt      = w_width;
                        n_shift    = w_msb_first ?
                                     (i_intensity[MAX_VALUE_BITS-1:0] << w_align) :
                                     i_intensity[MAX_VALUE_BITS-1:0];
                        if (w_width != '0) begin
                            n_state = ST_DATA;
                        end else if ((w_end_on && i_last_value) || w_sep_on) begin
                            n_state = ST_TAIL;
                        end
                    end
                end
            end

            ST_GAP: begin
                w_sym_last = (r_cnt == CNT_W'(1)) && (r_starts == '0);
                if (w_load) begin
                    n_symbol = r_symbol_gap;
                    n_kind   = KIND_GAP;
                    if (r_cnt == CNT_W'(1)) begin
                        if (r_starts != '0) begin
                            n_state = ST_START;
                            n_cnt   = CNT_W'(r_starts);
                        end else begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
            end

            ST_START: begin
                w_sym_last = (r_cnt == CNT_W'(1));
                if (w_load) begin
                    n_symbol = r_symbol_start;
                    n_kind   = KIND_START;
                    n_cnt    = r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end

            ST_DATA: begin
                w_sym_last = (r_cnt == CNT_W'(1)) && !r_tail;
                if (w_load) begin
                    n_symbol = w_bit ? r_symbol_one : r_symbol_zero;
                    n_kind   = w_bit ? KIND_ONE : KIND_ZERO;
                    n_cnt    = r_cnt - CNT_W'(1);
                    n_shift  = r_msb ? (r_shift << 1) : (r_shift >> 1);
                    if (r_cnt == CNT_W'(1)) begin
                        n_state = r_tail ? ST_TAIL : ST_IDLE;
                    end
                end
            end

            ST_TAIL: begin
                w_sym_last = 1'b1;
                if (w_load) begin
                    n_symbol = r_tail_end ? r_symbol_end : r_symbol_separator;
                    n_kind   = r_tail_end ? KIND_END : KIND_SEP;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
            n_last      = w_sym_last;
            n_symbol    = n_symbol & SYM_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_starts   <= n_starts;
        r_shift    <= n_shift;
        r_msb      <= n_msb;
        r_tail     <= n_tail;
        r_tail_end <= n_tail_end;
        r_symbol   <= n_symbol;
        r_kind     <= n_kind;
        r_last     <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_symbol      = r_symbol;
    assign o_symbol_kind = r_kind;
    assign o_last_of_run = r_last;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A busy sequencer always has symbols left to send.
    a_cnt_nonzero_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cnt != '0) || (r_state == ST_TAIL))
        else $error("sequencer busy with an empty counter");

    // A symbol loaded as the final one of its run returns the sequencer to idle.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_sym_last) |=> (r_state == ST_IDLE))
        else $error("run continued after its final symbol");

    // The sequencer goes idle only by loading the final symbol of its run.
    a_idle_only_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state != ST_IDLE) && (n_state == ST_IDLE)) |-> (w_load && w_sym_last))
        else $error("run ended without a final symbol");

    // A beat loaded into the output register is either taken or kept on the next cycle.
    a_out_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output beat dropped while stalled");

endmodule

`default_nettype wire
